// ===== hw/rtl/sts_pkg.sv =====
// Package for the serial transfer scheduler.
// Holds the command codes and the fixed field widths of the ports.
// No dependencies.
package sts_pkg;

  typedef enum logic [1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_ALARM    = 2'd2,
    CMD_SYNC     = 2'd3
  } cmd_e;

  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned MASK_W  = 4;

endpackage

// ===== hw/rtl/sts_rr_pick.sv =====
// Rotating priority pick over the channel request vector of the scheduler.
// Searches the channels after the origin and wraps around; no dependencies.
module sts_rr_pick #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic [NUM_CHANNELS-1:0]         req_i,
  input  logic [$clog2(NUM_CHANNELS)-1:0] origin_i,
  output logic                            found_o,
  output logic [$clog2(NUM_CHANNELS)-1:0] idx_o
);

  localparam int unsigned CW = $clog2(NUM_CHANNELS);

  always_comb begin
    logic [CW:0] pos;
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = 1; i <= NUM_CHANNELS; i++) begin
      pos = {1'b0, origin_i} + (CW+1)'(i);
      // wrap once; the sum stays below twice the channel count
      if (pos >= (CW+1)'(NUM_CHANNELS)) begin
        pos = pos - (CW+1)'(NUM_CHANNELS);
      end
      if (!found_o && req_i[pos[CW-1:0]]) begin
        found_o = 1'b1;
        idx_o   = pos[CW-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/serial_transfer_scheduler.sv =====
// Serial transfer scheduler: one shared engine, one waiting slot per channel.
// A transaction is taken into the input register, decoded there against the
// scheduler state, and its result is written into the result register.
// Throughput: one transaction per cycle; the input register and the result
// register form a two-entry pipeline, so a stalled result blocks input once the
// input register also holds a transaction.
// Reset clears the engine, the slot valid bits and the completion times.
module serial_transfer_scheduler #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned TIME_BITS    = 32,
  parameter int unsigned TAG_BITS     = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sts_pkg::cmd_e                command_i,
  input  logic [sts_pkg::CHAN_W-1:0]   chan_i,
  input  logic [sts_pkg::DELAY_W-1:0]  delay_i,
  input  logic [sts_pkg::LEN_W-1:0]    out_bytes_i,
  input  logic [sts_pkg::LEN_W-1:0]    in_bytes_i,
  input  logic [sts_pkg::TAG_W-1:0]    request_tag_i,
  input  logic [sts_pkg::NOW_W-1:0]    now_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic                         started_o,
  output logic [sts_pkg::CHAN_W-1:0]   start_chan_o,
  output logic [sts_pkg::TAG_W-1:0]    start_tag_o,
  output logic [sts_pkg::LEN_W-1:0]    start_out_bytes_o,
  output logic [sts_pkg::LEN_W-1:0]    start_in_bytes_o,
  output logic                         finished_o,
  output logic [sts_pkg::CHAN_W-1:0]   finished_chan_o,
  output logic [sts_pkg::TAG_W-1:0]    finished_tag_o,
  output logic                         engine_busy_o,
  output logic [sts_pkg::MASK_W-1:0]   pending_mask_o
);

  import sts_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CHANNELS);

  // pipeline control
  logic s1_valid_q, out_valid_q, adv, step;

  // input register
  cmd_e                 cmd_q;
  logic [CHAN_W-1:0]    chan_q;
  logic [DELAY_W-1:0]   delay_q;
  logic [LEN_W-1:0]     ob_q, ib_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [TIME_BITS-1:0] now_q;

  // scheduler state
  logic                 act_valid_q, act_valid_d;
  logic [CW-1:0]        act_chan_q, act_chan_d;
  logic [TAG_BITS-1:0]  act_tag_q, act_tag_d;
  logic [NUM_CHANNELS-1:0] slot_valid_q, slot_valid_d;
  logic [TIME_BITS-1:0] slot_fire_q [NUM_CHANNELS];
  logic [TAG_BITS-1:0]  slot_tag_q  [NUM_CHANNELS];
  logic [LEN_W-1:0]     slot_ob_q   [NUM_CHANNELS];
  logic [LEN_W-1:0]     slot_ib_q   [NUM_CHANNELS];
  logic [TIME_BITS-1:0] last_done_q [NUM_CHANNELS];

  // slot write and completion write requests
  logic                 slot_wr;
  logic                 done_wr;

  // result next values
  logic                 accepted_d, started_d, finished_d;
  logic [CHAN_W-1:0]    start_chan_d, finished_chan_d;
  logic [TAG_W-1:0]     start_tag_d, finished_tag_d;
  logic [LEN_W-1:0]     start_ob_d, start_ib_d;
  logic [MASK_W-1:0]    pending_d;

  // result register
  logic                 accepted_q, started_q, finished_q, busy_q;
  logic [CHAN_W-1:0]    start_chan_q, finished_chan_q;
  logic [TAG_W-1:0]     start_tag_q, finished_tag_q;
  logic [LEN_W-1:0]     start_ob_q, start_ib_q;
  logic [MASK_W-1:0]    pending_q;

  // decode helpers
  logic                 ch_ok;
  logic [CW-1:0]        chx;
  logic [TIME_BITS:0]   fire_sum;
  logic [TIME_BITS-1:0] fire;
  logic [NUM_CHANNELS-1:0] fired;
  logic [CW-1:0]        origin;
  logic                 pick_found;
  logic [CW-1:0]        pick_idx;

  assign adv        = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;

  assign ch_ok = int'(chan_q) < NUM_CHANNELS;
  assign chx   = CW'(chan_q);

  // fire time: now, or delay after the last completion, saturating
  assign fire_sum = (TIME_BITS+1)'(delay_q) + {1'b0, last_done_q[chx]};
  always_comb begin
    if (delay_q == '0) begin
      fire = now_q;
    end else if (fire_sum[TIME_BITS]) begin
      fire = {TIME_BITS{1'b1}};
    end else begin
      fire = fire_sum[TIME_BITS-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      fired[c] = slot_valid_q[c] && (slot_fire_q[c] <= now_q);
    end
  end

  // search origin: sync always from 0; complete from the finished channel, else last channel
  always_comb begin
    if (cmd_q == CMD_SYNC) begin
      origin = '0;
    end else if (act_valid_q) begin
      origin = act_chan_q;
    end else begin
      origin = CW'(NUM_CHANNELS - 1);
    end
  end

  sts_rr_pick #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_pick (
    .req_i    (fired),
    .origin_i (origin),
    .found_o  (pick_found),
    .idx_o    (pick_idx)
  );

  always_comb begin
    act_valid_d     = act_valid_q;
    act_chan_d      = act_chan_q;
    act_tag_d       = act_tag_q;
    slot_valid_d    = slot_valid_q;
    slot_wr         = 1'b0;
    done_wr         = 1'b0;
    accepted_d      = 1'b0;
    started_d       = 1'b0;
    start_chan_d    = '0;
    start_tag_d     = '0;
    start_ob_d      = '0;
    start_ib_d      = '0;
    finished_d      = 1'b0;
    finished_chan_d = '0;
    finished_tag_d  = '0;

    unique case (cmd_q)
      CMD_SUBMIT: begin
        if (ch_ok && !slot_valid_q[chx] && !(act_valid_q && act_chan_q == chx)) begin
          accepted_d = 1'b1;
          if (now_q >= fire && !act_valid_q) begin
            act_valid_d  = 1'b1;
            act_chan_d   = chx;
            act_tag_d    = tag_q;
            started_d    = 1'b1;
            start_chan_d = CHAN_W'(chx);
            start_tag_d  = TAG_W'(tag_q);
            start_ob_d   = ob_q;
            start_ib_d   = ib_q;
          end else begin
            slot_valid_d[chx] = 1'b1;
            slot_wr           = 1'b1;
          end
        end
      end
      CMD_ALARM: begin
        if (ch_ok && slot_valid_q[chx] && !act_valid_q) begin
          act_valid_d       = 1'b1;
          act_chan_d        = chx;
          act_tag_d         = slot_tag_q[chx];
          slot_valid_d[chx] = 1'b0;
          started_d         = 1'b1;
          start_chan_d      = CHAN_W'(chx);
          start_tag_d       = TAG_W'(slot_tag_q[chx]);
          start_ob_d        = slot_ob_q[chx];
          start_ib_d        = slot_ib_q[chx];
        end
      end
      CMD_COMPLETE, CMD_SYNC: begin
        if (act_valid_q) begin
          done_wr         = 1'b1;
          finished_d      = 1'b1;
          finished_chan_d = CHAN_W'(act_chan_q);
          finished_tag_d  = TAG_W'(act_tag_q);
          act_valid_d     = 1'b0;
        end
        // the finished channel never holds a slot, so the search is unaffected
        if (pick_found) begin
          act_valid_d            = 1'b1;
          act_chan_d             = pick_idx;
          act_tag_d              = slot_tag_q[pick_idx];
          slot_valid_d[pick_idx] = 1'b0;
          started_d              = 1'b1;
          start_chan_d           = CHAN_W'(pick_idx);
          start_tag_d            = TAG_W'(slot_tag_q[pick_idx]);
          start_ob_d             = slot_ob_q[pick_idx];
          start_ib_d             = slot_ib_q[pick_idx];
        end
      end
    endcase

    pending_d = '0;
    for (int c = 0; c < NUM_CHANNELS && c < MASK_W; c++) begin
      pending_d[c] = slot_valid_d[c];
    end
  end

  // control and reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      act_valid_q  <= 1'b0;
      act_chan_q   <= '0;
      act_tag_q    <= '0;
      slot_valid_q <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        last_done_q[c] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (step) begin
        act_valid_q  <= act_valid_d;
        act_chan_q   <= act_chan_d;
        act_tag_q    <= act_tag_d;
        slot_valid_q <= slot_valid_d;
        if (done_wr) begin
          last_done_q[act_chan_q] <= now_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      chan_q  <= chan_i;
      delay_q <= delay_i;
      ob_q    <= out_bytes_i;
      ib_q    <= in_bytes_i;
      tag_q   <= TAG_BITS'(request_tag_i);
      now_q   <= TIME_BITS'(now_i);
    end
    if (step && slot_wr) begin
      slot_fire_q[chx] <= fire;
      slot_tag_q[chx]  <= tag_q;
      slot_ob_q[chx]   <= ob_q;
      slot_ib_q[chx]   <= ib_q;
    end
    if (step) begin
      accepted_q      <= accepted_d;
      started_q       <= started_d;
      start_chan_q    <= start_chan_d;
      start_tag_q     <= start_tag_d;
      start_ob_q      <= start_ob_d;
      start_ib_q      <= start_ib_d;
      finished_q      <= finished_d;
      finished_chan_q <= finished_chan_d;
      finished_tag_q  <= finished_tag_d;
      busy_q          <= act_valid_d;
      pending_q       <= pending_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign started_o         = started_q;
  assign start_chan_o      = start_chan_q;
  assign start_tag_o       = start_tag_q;
  assign start_out_bytes_o = start_ob_q;
  assign start_in_bytes_o  = start_ib_q;
  assign finished_o        = finished_q;
  assign finished_chan_o   = finished_chan_q;
  assign finished_tag_o    = finished_tag_q;
  assign engine_busy_o     = busy_q;
  assign pending_mask_o    = pending_q;

endmodule

// ===== tb/sv/sched_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the serial transfer scheduler testbench.
// Tracks the scheduler state on every input transaction and compares each output
// transaction with the oldest prediction. Depends on sts_pkg.
module sched_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  sts_pkg::cmd_e                command_i,
  input  logic [sts_pkg::CHAN_W-1:0]   chan_i,
  input  logic [sts_pkg::DELAY_W-1:0]  delay_i,
  input  logic [sts_pkg::LEN_W-1:0]    out_bytes_i,
  input  logic [sts_pkg::LEN_W-1:0]    in_bytes_i,
  input  logic [sts_pkg::TAG_W-1:0]    request_tag_i,
  input  logic [sts_pkg::NOW_W-1:0]    now_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         accepted_i,
  input  logic                         started_i,
  input  logic [sts_pkg::CHAN_W-1:0]   start_chan_i,
  input  logic [sts_pkg::TAG_W-1:0]    start_tag_i,
  input  logic [sts_pkg::LEN_W-1:0]    start_out_bytes_i,
  input  logic [sts_pkg::LEN_W-1:0]    start_in_bytes_i,
  input  logic                         finished_i,
  input  logic [sts_pkg::CHAN_W-1:0]   finished_chan_i,
  input  logic [sts_pkg::TAG_W-1:0]    finished_tag_i,
  input  logic                         engine_busy_i,
  input  logic [sts_pkg::MASK_W-1:0]   pending_mask_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  waiting_cnt_o
);

  import sts_pkg::*;

  localparam int unsigned NCH = 4;
  localparam logic [NOW_W-1:0] TIME_SAT = '1;

  typedef struct packed {
    logic              accepted;
    logic              started;
    logic [CHAN_W-1:0] start_chan;
    logic [TAG_W-1:0]  start_tag;
    logic [LEN_W-1:0]  start_out_bytes;
    logic [LEN_W-1:0]  start_in_bytes;
    logic              finished;
    logic [CHAN_W-1:0] finished_chan;
    logic [TAG_W-1:0]  finished_tag;
    logic              engine_busy;
    logic [MASK_W-1:0] pending_mask;
  } sched_result_t;

  logic              eng_busy;
  logic [CHAN_W-1:0] eng_chan;
  logic [TAG_W-1:0]  eng_tag;
  logic [NCH-1:0]    slot_live;
  logic [NOW_W-1:0]  slot_fire [NCH];
  logic [TAG_W-1:0]  slot_tag [NCH];
  logic [LEN_W-1:0]  slot_out [NCH];
  logic [LEN_W-1:0]  slot_in [NCH];
  logic [NOW_W-1:0]  done_at [NCH];

  sched_result_t     step_res;
  sched_result_t     head;
  sched_result_t     result_q [$];
  int unsigned       mismatches;

  function automatic void engine_launch(logic [CHAN_W-1:0] c, logic [TAG_W-1:0] tag,
                                        logic [LEN_W-1:0] ob, logic [LEN_W-1:0] ib);
    eng_busy = 1'b1;
    eng_chan = c;
    eng_tag  = tag;
    step_res.started         = 1'b1;
    step_res.start_chan      = c;
    step_res.start_tag       = tag;
    step_res.start_out_bytes = ob;
    step_res.start_in_bytes  = ib;
  endfunction

  function automatic void launch_slot(logic [CHAN_W-1:0] c);
    engine_launch(c, slot_tag[c], slot_out[c], slot_in[c]);
    slot_live[c] = 1'b0;
  endfunction

  // Walk the channels after 'from' in rotating order; start the first fired slot.
  function automatic void start_next_fired(logic [CHAN_W-1:0] from, logic [NOW_W-1:0] now);
    logic [CHAN_W-1:0] c;
    logic              found;
    c     = from;
    found = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      c = c + 1'b1;
      if (!found && slot_live[c] && slot_fire[c] <= now) begin
        found = 1'b1;
        launch_slot(c);
      end
    end
  endfunction

  // End the active transfer if there is one; returns where the search starts.
  function automatic logic [CHAN_W-1:0] retire_active(logic [NOW_W-1:0] now,
                                                      logic [CHAN_W-1:0] idle_from);
    retire_active = idle_from;
    if (eng_busy) begin
      done_at[eng_chan]      = now;
      step_res.finished      = 1'b1;
      step_res.finished_chan = eng_chan;
      step_res.finished_tag  = eng_tag;
      eng_busy               = 1'b0;
      retire_active          = eng_chan;
    end
  endfunction

  function automatic sched_result_t schedule_step(cmd_e cmd, logic [CHAN_W-1:0] ch,
                                                  logic [DELAY_W-1:0] delay,
                                                  logic [LEN_W-1:0] ob, logic [LEN_W-1:0] ib,
                                                  logic [TAG_W-1:0] tag,
                                                  logic [NOW_W-1:0] now);
    logic [NOW_W:0]    fire_sum;
    logic [NOW_W-1:0]  fire;
    logic [CHAN_W-1:0] origin;
    step_res = '0;
    case (cmd)
      CMD_SUBMIT: begin
        if (!slot_live[ch] && !(eng_busy && eng_chan == ch)) begin
          fire_sum = {1'b0, done_at[ch]} + delay;
          if (delay == '0) begin
            fire = now;
          end else if (fire_sum[NOW_W]) begin
            fire = TIME_SAT;
          end else begin
            fire = fire_sum[NOW_W-1:0];
          end
          step_res.accepted = 1'b1;
          if (now >= fire && !eng_busy) begin
            engine_launch(ch, tag, ob, ib);
          end else begin
            slot_live[ch] = 1'b1;
            slot_fire[ch] = fire;
            slot_tag[ch]  = tag;
            slot_out[ch]  = ob;
            slot_in[ch]   = ib;
          end
        end
      end
      CMD_COMPLETE: begin
        // with the engine idle the search begins at channel 0
        origin = retire_active(now, CHAN_W'(NCH - 1));
        start_next_fired(origin, now);
      end
      CMD_ALARM: begin
        if (slot_live[ch] && !eng_busy) launch_slot(ch);
      end
      CMD_SYNC: begin
        origin = retire_active(now, '0);
        start_next_fired('0, now);
      end
    endcase
    step_res.engine_busy  = eng_busy;
    step_res.pending_mask = slot_live;
    return step_res;
  endfunction

  function automatic int field_miss(string name, logic [31:0] want, logic [31:0] got);
    field_miss = 0;
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      field_miss = 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_busy  = 1'b0;
      eng_chan  = '0;
      eng_tag   = '0;
      slot_live = '0;
      for (int c = 0; c < NCH; c++) done_at[c] = '0;
      result_q.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      waiting_cnt_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          head = result_q.pop_front();
          mismatches += field_miss("accepted", head.accepted, accepted_i);
          mismatches += field_miss("started", head.started, started_i);
          mismatches += field_miss("start_chan", head.start_chan, start_chan_i);
          mismatches += field_miss("start_tag", head.start_tag, start_tag_i);
          mismatches += field_miss("start_out_bytes", head.start_out_bytes,
                                   start_out_bytes_i);
          mismatches += field_miss("start_in_bytes", head.start_in_bytes, start_in_bytes_i);
          mismatches += field_miss("finished", head.finished, finished_i);
          mismatches += field_miss("finished_chan", head.finished_chan, finished_chan_i);
          mismatches += field_miss("finished_tag", head.finished_tag, finished_tag_i);
          mismatches += field_miss("engine_busy", head.engine_busy, engine_busy_i);
          mismatches += field_miss("pending_mask", head.pending_mask, pending_mask_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(schedule_step(command_i, chan_i, delay_i, out_bytes_i,
                                         in_bytes_i, request_tag_i, now_i));
      end
      mismatch_cnt_o <= mismatches;
      waiting_cnt_o  <= result_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the serial transfer scheduler testbench: clock, reset, stimulus, verdict.
// Drives u_dut and hands both channels to sched_checker. Depends on sts_pkg.
module testbench;
  import sts_pkg::*;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned BLOCKS      = 13;
  localparam int unsigned BLOCK_ITEMS = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  cmd_e               command_i;
  logic [CHAN_W-1:0]  chan_i;
  logic [DELAY_W-1:0] delay_i;
  logic [LEN_W-1:0]   out_bytes_i;
  logic [LEN_W-1:0]   in_bytes_i;
  logic [TAG_W-1:0]   request_tag_i;
  logic [NOW_W-1:0]   now_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               accepted_o;
  logic               started_o;
  logic [CHAN_W-1:0]  start_chan_o;
  logic [TAG_W-1:0]   start_tag_o;
  logic [LEN_W-1:0]   start_out_bytes_o;
  logic [LEN_W-1:0]   start_in_bytes_o;
  logic               finished_o;
  logic [CHAN_W-1:0]  finished_chan_o;
  logic [TAG_W-1:0]   finished_tag_o;
  logic               engine_busy_o;
  logic [MASK_W-1:0]  pending_mask_o;

  int unsigned        mismatch_cnt;
  int unsigned        waiting_cnt;
  int unsigned        idle_pct = 12;
  int unsigned        quiet_cycles = 0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;
  logic [NOW_W-1:0]   sys_time;

  serial_transfer_scheduler u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .chan_i            (chan_i),
    .delay_i           (delay_i),
    .out_bytes_i       (out_bytes_i),
    .in_bytes_i        (in_bytes_i),
    .request_tag_i     (request_tag_i),
    .now_i             (now_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .started_o         (started_o),
    .start_chan_o      (start_chan_o),
    .start_tag_o       (start_tag_o),
    .start_out_bytes_o (start_out_bytes_o),
    .start_in_bytes_o  (start_in_bytes_o),
    .finished_o        (finished_o),
    .finished_chan_o   (finished_chan_o),
    .finished_tag_o    (finished_tag_o),
    .engine_busy_o     (engine_busy_o),
    .pending_mask_o    (pending_mask_o)
  );

  sched_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .chan_i            (chan_i),
    .delay_i           (delay_i),
    .out_bytes_i       (out_bytes_i),
    .in_bytes_i        (in_bytes_i),
    .request_tag_i     (request_tag_i),
    .now_i             (now_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_i        (accepted_o),
    .started_i         (started_o),
    .start_chan_i      (start_chan_o),
    .start_tag_i       (start_tag_o),
    .start_out_bytes_i (start_out_bytes_o),
    .start_in_bytes_i  (start_in_bytes_o),
    .finished_i        (finished_o),
    .finished_chan_i   (finished_chan_o),
    .finished_tag_i    (finished_tag_o),
    .engine_busy_i     (engine_busy_o),
    .pending_mask_i    (pending_mask_o),
    .mismatch_cnt_o    (mismatch_cnt),
    .waiting_cnt_o     (waiting_cnt)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $error("no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  function automatic void advance_time(logic [NOW_W-1:0] ticks);
    logic [NOW_W:0] sum;
    sum      = {1'b0, sys_time} + ticks;
    sys_time = sum[NOW_W] ? '1 : sum[NOW_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(0, 255));
    return LEN_W'($urandom_range(1, 128));
  endfunction

  // Hold valid and payload until the transaction is taken.
  task automatic send_item(cmd_e cmd, logic [CHAN_W-1:0] ch, logic [DELAY_W-1:0] dly,
                           logic [LEN_W-1:0] ob, logic [LEN_W-1:0] ib,
                           logic [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    chan_i        <= ch;
    delay_i       <= dly;
    out_bytes_i   <= ob;
    in_bytes_i    <= ib;
    request_tag_i <= tag;
    now_i         <= sys_time;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random(bit wide_delays);
    int unsigned        pick;
    int unsigned        dpick;
    cmd_e               cmd;
    logic [DELAY_W-1:0] dly;
    pick  = $urandom_range(0, 99);
    dpick = $urandom_range(0, 99);
    if (pick < 45) begin
      cmd = CMD_SUBMIT;
    end else if (pick < 75) begin
      cmd = CMD_COMPLETE;
    end else if (pick < 85) begin
      cmd = CMD_ALARM;
    end else begin
      cmd = CMD_SYNC;
    end
    if (dpick < 40) begin
      dly = '0;
    end else if (dpick < (wide_delays ? 60 : 80)) begin
      dly = DELAY_W'($urandom_range(1, 64));
    end else if (dpick < (wide_delays ? 70 : 95)) begin
      dly = DELAY_W'($urandom_range(65, 2000));
    end else begin
      dly = DELAY_W'($urandom_range(0, 65535));
    end
    advance_time($urandom_range(0, 40));
    send_item(cmd, CHAN_W'($urandom_range(0, 3)), dly, rand_len(), rand_len(),
              TAG_W'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_SUBMIT;
    chan_i        = '0;
    delay_i       = '0;
    out_bytes_i   = '0;
    in_bytes_i    = '0;
    request_tag_i = '0;
    now_i         = '0;
    sys_time      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // events with the engine idle and nothing pending
    advance_time(10);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_SYNC, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_ALARM, 2'd2, 16'd0, 8'd1, 8'd1, 8'h00);
    // start at once, reject on active channel and on full slot, queue behind busy engine
    advance_time(5);
    send_item(CMD_SUBMIT, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_SUBMIT, 2'd0, 16'd0, 8'd9, 8'd9, 8'h11);
    send_item(CMD_SUBMIT, 2'd1, 16'd0, 8'd128, 8'd128, 8'hFF);
    send_item(CMD_SUBMIT, 2'd1, 16'd7, 8'd2, 8'd2, 8'h22);
    send_item(CMD_SUBMIT, 2'd2, 16'hFFFF, 8'd0, 8'd255, 8'hA5);
    send_item(CMD_SUBMIT, 2'd3, 16'd5, 8'd3, 8'd4, 8'h3C);
    // rotating hand-off on complete and sync
    advance_time(5);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_SYNC, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    // alarm launches a slot that has not fired, then finds nothing
    send_item(CMD_ALARM, 2'd2, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_ALARM, 2'd2, 16'd0, 8'd1, 8'd1, 8'h00);
    advance_time(10);
    send_item(CMD_SUBMIT, 2'd0, 16'd3, 8'd64, 8'd32, 8'h5A);
    send_item(CMD_SUBMIT, 2'd1, 16'd0, 8'd16, 8'd8, 8'h81);
    send_item(CMD_ALARM, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    // sync picks channel 1 ahead of channel 0
    send_item(CMD_SYNC, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_SUBMIT, 2'd3, 16'd40000, 8'd100, 8'd90, 8'h7E);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_SUBMIT, 2'd2, 16'd0, 8'd77, 8'd66, 8'hC3);
    send_item(CMD_SUBMIT, 2'd1, 16'd60000, 8'd128, 8'd1, 8'h0F);
    advance_time(50000);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_COMPLETE, 2'd0, 16'd0, 8'd1, 8'd1, 8'h00);
    send_item(CMD_ALARM, 2'd1, 16'd0, 8'd1, 8'd1, 8'h00);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      idle_pct = (blk == 3) ? 0 : 12;
      if (blk == 5) hold_req <= 1'b1;
      if (blk == 7) begin
        // drain the pipeline before going on
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (waiting_cnt == 0);
        @(posedge clk_i);
      end
      // the last two blocks run close to the top of the time range
      if (blk == BLOCKS - 2) begin
        sys_time = 32'hFFFF_8000;
      end else if (blk > 0 && blk < BLOCKS - 2) begin
        advance_time($urandom_range(0, 32'h0800_0000));
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (blk == BLOCKS - 1 && n == BLOCK_ITEMS - 10) sys_time = '1;
        send_random(blk >= BLOCKS - 2);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (waiting_cnt == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sts_pkg.sv
hw/rtl/sts_rr_pick.sv
hw/rtl/serial_transfer_scheduler.sv
tb/sv/sched_checker.sv
tb/sv/testbench.sv
